/* rtl/core/erng_pkg.sv */
// Shared constants and types for the entropy pool random generator.
`default_nettype none

package erng_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [2:0]        opcode_t;
    typedef logic [1:0]        mul_step_t;

    // Opcodes
    localparam opcode_t OP_SEED_BEGIN  = 3'd0;
    localparam opcode_t OP_SEED_JITTER = 3'd1;
    localparam opcode_t OP_SEED_FINISH = 3'd2;
    localparam opcode_t OP_ADD_ENTROPY = 3'd3;
    localparam opcode_t OP_GENERATE    = 3'd4;

    // Status codes
    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_NOT_SEEDED = 1'b1;

    // Mixing constants
    localparam word_t K_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
    localparam word_t K_MIX1   = 64'hBF58_476D_1CE4_E5B9;
    localparam word_t K_MIX2   = 64'h94D0_49BB_1331_11EB;
    localparam word_t K_SEED   = 64'h243F_6A88_85A3_08D3;

    // Partial product order of the shared multiplier
    localparam mul_step_t MUL_STEP_LL = 2'd0;
    localparam mul_step_t MUL_STEP_LH = 2'd1;
    localparam mul_step_t MUL_STEP_HL = 2'd2;

endpackage

`default_nettype wire

/* rtl/core/entropy_pool_random_generator_top.sv */
// Top level of the entropy pool random generator: sequencer, pool and output register.
`default_nettype none

// Keeps a 64-bit entropy pool and a seeded flag, and runs one opcode per input
// item, returning one result item (random_word, status) for each. The block
// takes one item at a time and drops in_ready until its result sits in the
// output register. seed_begin, seed_jitter, seed_finish, unused opcodes and a
// generate before seeding go straight to the result; add_entropy and a seeded
// generate wait on a single shared 32x32 multiplier that builds each 64-bit
// product in three partial products; add_entropy needs one such product and
// generate two. A finished result waits in the output register while the
// next item is taken; a second result waits until the first has been taken.
// hw_rng_present is written through the cfg channel, which is always ready.
module entropy_pool_random_generator_top
    import erng_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    // configuration
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire          cfg_data,
    // input items
    input  wire          in_valid,
    output logic         in_ready,
    input  wire  [2:0]   opcode,
    input  wire  [63:0]  value,
    input  wire  [63:0]  stamp_a,
    input  wire  [63:0]  stamp_b,
    input  wire  [63:0]  hw_word,
    input  wire          hw_ok,
    // result items
    output logic         out_valid,
    input  wire          out_ready,
    output logic [63:0]  random_word,
    output logic         status
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL1  = 6'b000010,
        S_WAIT1 = 6'b000100,
        S_MUL2  = 6'b001000,
        S_WAIT2 = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t  state_reg;
    state_t  state_next;

    logic    hw_present_reg;
    logic    seeded_reg;
    logic    seeded_next;
    word_t   pool_reg;
    word_t   pool_next;

    opcode_t op_reg;
    word_t   value_reg;
    word_t   stamp_reg;
    word_t   hw_word_reg;
    logic    hw_use_reg;
    word_t   z_reg;
    word_t   z_next;
    word_t   word_reg;
    word_t   word_next;
    logic    status_reg;
    logic    status_next;

    logic    out_valid_reg;
    word_t   out_word_reg;
    logic    out_status_reg;

    logic    accept;
    logic    slot_free;
    logic    hw_use_in;
    word_t   hw_mask_in;
    word_t   hw_mask_reg;
    word_t   mix_out;

    logic    mul_start;
    word_t   mul_a;
    word_t   mul_b;
    logic    mul_done;
    word_t   mul_p;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign slot_free  = !out_valid_reg || out_ready;
    assign hw_use_in  = hw_present_reg && hw_ok;
    assign hw_mask_in = hw_use_in ? hw_word : '0;
    assign hw_mask_reg = hw_use_reg ? hw_word_reg : '0;

    // Final SplitMix64 fold of the second product
    assign mix_out = mul_p ^ (mul_p >> 31);

    // Shared multiplier operand selection
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = z_reg ^ (z_reg >> 27);
        mul_b     = K_MIX2;
        case (state_reg)
            S_MUL1:
            begin
                mul_start = 1'b1;
                if (op_reg == OP_GENERATE)
                begin
                    mul_a = pool_reg ^ (pool_reg >> 30);
                    mul_b = K_MIX1;
                end
                else
                begin
                    mul_a = value_reg;
                    mul_b = K_GOLDEN;
                end
            end
            S_MUL2:
            begin
                mul_start = 1'b1;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    erng_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // Sequencer and pool update
    always_comb
    begin
        state_next  = state_reg;
        pool_next   = pool_reg;
        seeded_next = seeded_reg;
        z_next      = z_reg;
        word_next   = word_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    word_next   = '0;
                    status_next = STATUS_OK;
                    state_next  = S_DONE;
                    case (opcode)
                        OP_SEED_BEGIN:
                        begin
                            pool_next   = K_SEED ^ value;
                            seeded_next = 1'b0;
                        end
                        OP_SEED_JITTER:
                        begin
                            pool_next = {pool_reg[WORD_W-2:0], stamp_a[0]} ^ (stamp_b >> 3);
                        end
                        OP_SEED_FINISH:
                        begin
                            pool_next   = pool_reg ^ hw_mask_in;
                            seeded_next = 1'b1;
                        end
                        OP_ADD_ENTROPY:
                        begin
                            state_next = S_MUL1;
                        end
                        OP_GENERATE:
                        begin
                            if (seeded_reg)
                            begin
                                pool_next  = (pool_reg ^ stamp_a) + K_GOLDEN;
                                state_next = S_MUL1;
                            end
                            else
                            begin
                                status_next = STATUS_NOT_SEEDED;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL1:
            begin
                state_next = S_WAIT1;
            end
            S_WAIT1:
            begin
                if (mul_done)
                begin
                    if (op_reg == OP_GENERATE)
                    begin
                        z_next     = mul_p;
                        state_next = S_MUL2;
                    end
                    else
                    begin
                        pool_next  = pool_reg ^ mul_p ^ stamp_reg;
                        state_next = S_DONE;
                    end
                end
            end
            S_MUL2:
            begin
                state_next = S_WAIT2;
            end
            S_WAIT2:
            begin
                if (mul_done)
                begin
                    word_next  = mix_out ^ hw_mask_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and pool
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pool_reg       <= '0;
            seeded_reg     <= 1'b0;
            hw_present_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pool_reg   <= pool_next;
            seeded_reg <= seeded_next;
            if (cfg_valid && cfg_ready)
            begin
                hw_present_reg <= cfg_data;
            end
            if (state_reg == S_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item payload and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= opcode;
            value_reg   <= value;
            stamp_reg   <= stamp_a;
            hw_word_reg <= hw_word;
            hw_use_reg  <= hw_use_in;
        end
        z_reg      <= z_next;
        word_reg   <= word_next;
        status_reg <= status_next;
        if (state_reg == S_DONE && slot_free)
        begin
            out_word_reg   <= word_reg;
            out_status_reg <= status_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign random_word = out_word_reg;
    assign status      = out_status_reg;

endmodule

`default_nettype wire

/* rtl/core/erng_mul.sv */
// Iterative 64x64 multiplier (low 64 bits) built on one 32x32 multiplier.
`default_nettype none

module erng_mul
    import erng_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    input  wire word_t op_a,
    input  wire word_t op_b,
    output logic       done,
    output word_t      product
);

    word_t                a_reg;
    word_t                b_reg;
    word_t                acc_reg;
    word_t                acc_next;
    mul_step_t            step_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [HALF_W-1:0]    m_a;
    logic [HALF_W-1:0]    m_b;
    word_t                m_prod;

    // Select the operand halves for the current partial product
    always_comb
    begin
        case (step_reg)
            MUL_STEP_LL:
            begin
                m_a = a_reg[HALF_W-1:0];
                m_b = b_reg[HALF_W-1:0];
            end
            MUL_STEP_LH:
            begin
                m_a = a_reg[HALF_W-1:0];
                m_b = b_reg[WORD_W-1:HALF_W];
            end
            default:
            begin
                m_a = a_reg[WORD_W-1:HALF_W];
                m_b = b_reg[HALF_W-1:0];
            end
        endcase
        m_prod = WORD_W'(m_a) * WORD_W'(m_b);
    end

    // Accumulate: the cross terms only reach the upper half
    always_comb
    begin
        if (step_reg == MUL_STEP_LL)
        begin
            acc_next = m_prod;
        end
        else
        begin
            acc_next = {acc_reg[WORD_W-1:HALF_W] + m_prod[HALF_W-1:0],
                        acc_reg[HALF_W-1:0]};
        end
    end

    // Track busy and done and advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= MUL_STEP_LL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= MUL_STEP_LL;
            end
            else if (busy_reg)
            begin
                if (step_reg == MUL_STEP_HL)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    step_reg <= MUL_STEP_LL;
                end
                else
                begin
                    step_reg <= step_reg + mul_step_t'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

/* bench/tb_entropy_pool_random_generator_top.sv */
// Self-checking testbench for the entropy pool random generator top level.
`timescale 1ns / 100ps

module tb_entropy_pool_random_generator_top;
    import erng_pkg::*;

    localparam int      IDLE_LIMIT     = 3000;
    localparam int      LONG_HOLD      = 90;
    localparam int      SETTLE_CYCLES  = 16;
    localparam int      REPORT_MAX     = 10;
    localparam int      RANDOM_CHUNKS  = 8;
    localparam int      CHUNK_REQS     = 106;
    localparam opcode_t OP_LAST_SPARE  = 3'd7;

    typedef struct {
        opcode_t op;
        word_t   value;
        word_t   stamp_a;
        word_t   stamp_b;
        word_t   hw_word;
        logic    hw_ok;
    } rng_req_t;

    typedef struct {
        word_t word;
        logic  status;
    } rng_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  opcode = '0;
    logic [63:0] value = '0;
    logic [63:0] stamp_a = '0;
    logic [63:0] stamp_b = '0;
    logic [63:0] hw_word = '0;
    logic        hw_ok = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] random_word;
    logic        status;

    // pool model
    word_t      pool_q = '0;
    logic       seeded_q = 1'b0;
    logic       hw_present_q = 1'b0;

    rng_req_t   pending_reqs[$];
    rng_resp_t  expected_words[$];
    rng_req_t   req_in_flight;
    int         send_gap = 0;
    int         send_gap_max = 0;
    int         sink_stall = 0;
    int         sink_stall_max = 0;
    int         hold_requests = 0;
    int         holds_served = 0;
    int         mismatches = 0;
    int         idle_cycles = 0;

    entropy_pool_random_generator_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .value       (value),
        .stamp_a     (stamp_a),
        .stamp_b     (stamp_b),
        .hw_word     (hw_word),
        .hw_ok       (hw_ok),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .random_word (random_word),
        .status      (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one opcode to the model pool and return the word it yields
    function automatic rng_resp_t step_pool(rng_req_t r);
        rng_resp_t res;
        word_t     z;
        logic      use_hw;
        res.word   = '0;
        res.status = STATUS_OK;
        use_hw     = hw_present_q && r.hw_ok;
        case (r.op)
            OP_SEED_BEGIN:
            begin
                pool_q   = K_SEED ^ r.value;
                seeded_q = 1'b0;
            end
            OP_SEED_JITTER:
            begin
                pool_q = {pool_q[WORD_W-2:0], r.stamp_a[0]} ^ (r.stamp_b >> 3);
            end
            OP_SEED_FINISH:
            begin
                if (use_hw)
                    pool_q = pool_q ^ r.hw_word;
                seeded_q = 1'b1;
            end
            OP_ADD_ENTROPY:
            begin
                pool_q = pool_q ^ (r.value * K_GOLDEN) ^ r.stamp_a;
            end
            OP_GENERATE:
            begin
                if (!seeded_q)
                    res.status = STATUS_NOT_SEEDED;
                else
                begin
                    pool_q = (pool_q ^ r.stamp_a) + K_GOLDEN;
                    z = (pool_q ^ (pool_q >> 30)) * K_MIX1;
                    z = (z ^ (z >> 27)) * K_MIX2;
                    z = z ^ (z >> 31);
                    if (use_hw)
                        z = z ^ r.hw_word;
                    res.word = z;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Sender: offer queued items, predict each one as it is taken
    always @(posedge clk)
    begin
        logic     taken;
        int       gap;
        rng_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            taken = in_valid && in_ready;
            gap   = send_gap;
            if (taken)
            begin
                expected_words.push_back(step_pool(req_in_flight));
                gap = $urandom_range(0, send_gap_max);
            end
            if (in_valid && !taken)
            begin
                // hold the offered item
            end
            else if (gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= gap - 1;
            end
            else if (pending_reqs.size() != 0)
            begin
                nxt = pending_reqs.pop_front();
                req_in_flight = nxt;
                opcode   <= nxt.op;
                value    <= nxt.value;
                stamp_a  <= nxt.stamp_a;
                stamp_b  <= nxt.stamp_b;
                hw_word  <= nxt.hw_word;
                hw_ok    <= nxt.hw_ok;
                in_valid <= 1'b1;
                send_gap <= 0;
            end
            else
            begin
                in_valid <= 1'b0;
                send_gap <= 0;
            end
        end
    end

    task automatic note_mismatch(input string what, input word_t want, input word_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Receiver: check each result against the oldest prediction, stall at random
    always @(posedge clk)
    begin
        int        st;
        rng_resp_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            sink_stall <= 0;
        end
        else
        begin
            st = sink_stall;
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    note_mismatch("unexpected result, random_word", '0, random_word);
                else
                begin
                    want = expected_words.pop_front();
                    if (random_word !== want.word)
                        note_mismatch("random_word", want.word, random_word);
                    if (status !== want.status)
                        note_mismatch("status", word_t'(want.status), word_t'(status));
                end
                st = $urandom_range(0, sink_stall_max);
            end
            if (hold_requests != holds_served)
            begin
                st = LONG_HOLD;
                holds_served <= hold_requests;
            end
            if (st > 0)
            begin
                out_ready  <= 1'b0;
                sink_stall <= st - 1;
            end
            else
            begin
                out_ready  <= 1'b1;
                sink_stall <= 0;
            end
        end
    end

    // Watchdog: give up when no channel has moved for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_entropy_pool_random_generator_top: errors");
                $finish;
            end
        end
    end

    function automatic word_t rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_req(input opcode_t op, input word_t v, input word_t a, input word_t b,
                             input word_t hw, input logic ok);
        rng_req_t r;
        r.op      = op;
        r.value   = v;
        r.stamp_a = a;
        r.stamp_b = b;
        r.hw_word = hw;
        r.hw_ok   = ok;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_random(input opcode_t op);
        queue_req(op, rand_word(), rand_word(), rand_word(), rand_word(), 1'($urandom));
    endtask

    task automatic write_hw_present(input logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        hw_present_q = v;
        @(negedge clk);
    endtask

    // Wait until every item is taken and every result has come back
    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid || expected_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly well-formed seeding sessions with random content, some noise
    task automatic queue_chunk(input int n_reqs);
        int      count;
        int      n;
        opcode_t op;
        count = 0;
        while (count < n_reqs)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                op = opcode_t'($urandom_range(0, OP_LAST_SPARE));
                queue_random(op);
                if (op <= OP_GENERATE)
                    count++;
            end
            else
            begin
                queue_random(OP_SEED_BEGIN);
                n = $urandom_range(1, 6);
                repeat (n) queue_random(OP_SEED_JITTER);
                count += n + 1;
                // now and then leave the pool unseeded
                if ($urandom_range(0, 9) != 0)
                begin
                    queue_random(OP_SEED_FINISH);
                    count++;
                end
                n = $urandom_range(1, 8);
                repeat (n)
                    queue_random(($urandom_range(0, 9) < 7) ? OP_GENERATE : OP_ADD_ENTROPY);
                count += n;
            end
        end
    endtask

    // Stimulus: reset, directed cases, then random chunks
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed cases with the hardware source present
        write_hw_present(1'b1);
        send_gap_max   = 2;
        sink_stall_max = 2;
        queue_req(OP_GENERATE, '1, '1, '1, '1, 1'b1);
        queue_req(OP_SEED_JITTER, '0, '1, '1, '0, 1'b0);
        queue_req(OP_ADD_ENTROPY, '1, '1, '0, '1, 1'b1);
        queue_req(OP_SEED_BEGIN, '0, '0, '0, '0, 1'b0);
        queue_req(OP_SEED_JITTER, '1, 64'd1, '1, '1, 1'b1);
        queue_req(OP_SEED_JITTER, '0, '0, '0, '0, 1'b0);
        queue_req(OP_SEED_FINISH, '0, '0, '0, '1, 1'b1);
        queue_req(OP_GENERATE, '0, '0, '0, '1, 1'b1);
        queue_req(OP_GENERATE, '1, '1, '1, '1, 1'b0);
        queue_req(OP_ADD_ENTROPY, '0, '0, '0, '0, 1'b0);
        queue_req(OP_ADD_ENTROPY, '1, '1, '1, '1, 1'b1);
        for (int k = OP_GENERATE + 1; k <= OP_LAST_SPARE; k++)
            queue_random(opcode_t'(k));
        queue_req(OP_GENERATE, '0, '1, '0, '0, 1'b1);
        queue_req(OP_SEED_BEGIN, '1, '1, '1, '1, 1'b1);
        queue_req(OP_GENERATE, '0, '0, '0, '1, 1'b1);
        queue_req(OP_SEED_FINISH, '1, '1, '1, '1, 1'b0);
        queue_req(OP_GENERATE, '1, '0, '1, '0, 1'b1);
        drain();

        // hardware word must now be ignored
        write_hw_present(1'b0);
        queue_req(OP_SEED_FINISH, '0, '0, '0, '1, 1'b1);
        queue_req(OP_GENERATE, '0, '0, '0, '1, 1'b1);
        queue_req(OP_GENERATE, '1, '1, '1, '1, 1'b0);
        queue_req(OP_ADD_ENTROPY, '1, '0, '1, '1, 1'b1);
        queue_req(OP_GENERATE, '0, '1, '0, '1, 1'b1);
        drain();

        // random chunks, idling pattern and configuration varied per chunk
        for (int c = 0; c < RANDOM_CHUNKS; c++)
        begin
            write_hw_present(1'($urandom_range(0, 1)));
            case (c % 3)
                0:
                begin
                    send_gap_max   = 6;
                    sink_stall_max = 6;
                end
                1:
                begin
                    send_gap_max   = 0;
                    sink_stall_max = 0;
                end
                default:
                begin
                    send_gap_max   = 6 * (c % 2);
                    sink_stall_max = 6 - send_gap_max;
                end
            endcase
            // long receiver hold-off while the sender keeps offering items
            if (c == 1 || c == 5)
                hold_requests++;
            queue_chunk(CHUNK_REQS);
            drain();
        end

        if (mismatches == 0)
            $display("tb_entropy_pool_random_generator_top: clean");
        else
            $display("tb_entropy_pool_random_generator_top: errors");
        $finish;
    end

endmodule
